@@ src/image_quarter_turn_rotator_defines.svh @@
// assertion macros for the quarter-turn image rotator
// standalone header, no dependencies; included by files that carry assertions
`ifndef IMAGE_QUARTER_TURN_ROTATOR_DEFINES_SVH
`define IMAGE_QUARTER_TURN_ROTATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IQTR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iqtr: same-cycle check failed");

// next-cycle implication, checked out of reset
`define IQTR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iqtr: next-cycle check failed");

`endif

@@ src/iqtr_pkg.sv @@
// shared types and constants for the quarter-turn image rotator
// no dependencies; imported by the controller, datapath and top level
package iqtr_pkg;

  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int PIX_PORT_W  = 24;
  localparam int GREY_BITS   = 8;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEL_LEFT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEL_TOP       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEL_RIGHT     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SEL_BOTTOM    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_TURNS = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOUR_MODE   = 3'd7;

  // item codes on func
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted beat
    logic prep;      // coordinate set-up stage
    logic map;       // source coordinate and position advance (fetch)
    logic write;     // store write and load count advance (load)
    logic addr;      // linear address multiply
    logic read;      // store read
    logic out_load;  // fill the output register
  } iqtr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_fetch;
  } iqtr_sts_t;

endpackage

@@ src/iqtr_ctrl.sv @@
// sequencing state machine for the quarter-turn image rotator
// depends on iqtr_pkg and image_quarter_turn_rotator_defines.svh
`include "image_quarter_turn_rotator_defines.svh"

module iqtr_ctrl import iqtr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  iqtr_sts_t sts,
  output iqtr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MAP,
    S_ADDR,
    S_READ,
    S_DELIVER
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_valid && in_ready;
    cmd.prep     = (state == S_PREP);
    cmd.map      = (state == S_MAP) && sts.item_fetch;
    cmd.write    = (state == S_MAP) && !sts.item_fetch;
    cmd.addr     = (state == S_ADDR);
    cmd.read     = (state == S_READ);
    cmd.out_load = (state == S_DELIVER) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_PREP;
      S_PREP:    state_next = S_MAP;
      S_MAP:     state_next = sts.item_fetch ? S_ADDR : S_IDLE;
      S_ADDR:    state_next = S_READ;
      S_READ:    state_next = S_DELIVER;
      S_DELIVER: if (cmd.out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `IQTR_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load && out_valid, out_ready)
  `IQTR_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.capture, !in_ready)
  `IQTR_ASSERT_IMP(a_write_on_load, clk, rst, cmd.write, sts.item_fetch == FUNC_LOAD)
  `IQTR_ASSERT_NEXT(a_result_shown, clk, rst, cmd.out_load, out_valid)

endmodule

@@ src/iqtr_datapath.sv @@
// config registers, coordinate mapping, pixel store and output register
// depends on iqtr_pkg; driven by iqtr_ctrl commands
module iqtr_datapath import iqtr_pkg::*; #(
  parameter int MAX_DIM    = 256,
  parameter int PIXEL_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   func,
  input  logic [PIX_PORT_W-1:0]  pixel_in,
  output logic [PIX_PORT_W-1:0]  pixel_out,
  output logic                   last_pixel,
  input  iqtr_cmd_t              cmd,
  output iqtr_sts_t              sts
);

  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int POS_W       = $clog2(MAX_DIM);
  localparam int CW          = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

  // configuration registers
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [CFG_DATA_W-1:0] sel_left;
  logic [CFG_DATA_W-1:0] sel_top;
  logic [CFG_DATA_W-1:0] sel_right;
  logic [CFG_DATA_W-1:0] sel_bottom;
  logic [1:0]            quarter_turns;
  logic                  colour_mode;

  // running state
  logic [ADDR_W-1:0] load_count;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_col;

  // captured beat
  logic                  item_fetch;
  logic [PIXEL_BITS-1:0] item_pixel;

  // set-up stage registers
  logic [CW-1:0]    a_r, a_c, a_i, a_j, a_n, a_ow, a_oh;
  logic             a_inreg, a_full;
  logic [TOT_W-1:0] a_total;

  // mapping stage registers
  logic [POS_W-1:0] b_sr, b_sc;
  logic             b_last;

  logic [ADDR_W-1:0]     rd_addr;
  logic [PIXEL_BITS-1:0] rdata;
  logic [PIXEL_BITS-1:0] store [STORE_DEPTH];

  function automatic logic [CW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve == '0) return CW'(1);
    else if (ve > CW'(MAX_DIM)) return CW'(MAX_DIM);
    else return ve;
  endfunction

  logic [CW-1:0] w, h, sl, st, sre, sb;
  logic          whole, square, full, restart;
  logic [CW-1:0] ow, oh, r0, c0, r, c;

  always_comb begin
    w      = clamp_dim(image_width);
    h      = clamp_dim(image_height);
    sl     = CW'(sel_left);
    st     = CW'(sel_top);
    sre    = CW'(sel_right);
    sb     = CW'(sel_bottom);
    whole  = (sl == '0) && (st == '0) && (sre == w) && (sb == h);
    square = (sre > sl) && (sb > st) && ((sre - sl) == (sb - st)) &&
             (sre <= w) && (sb <= h);
    full   = !square && whole;
    ow     = (full && quarter_turns[0]) ? h : w;
    oh     = (full && quarter_turns[0]) ? w : h;
    r0     = CW'(out_row);
    c0     = CW'(out_col);
    // position off the current output image starts over at the origin
    restart = (r0 >= oh) || (c0 >= ow);
    r      = restart ? '0 : r0;
    c      = restart ? '0 : c0;
  end

  // mapping stage logic
  logic [CW-1:0] li, lj, fr, fc, src_r, src_c, c_inc, r_inc;

  always_comb begin
    li = a_i;
    lj = a_j;
    fr = a_r;
    fc = a_c;
    unique case (quarter_turns)
      2'd0: begin
        li = a_i;
        lj = a_j;
      end
      2'd1: begin
        li = a_n - CW'(1) - a_j;
        lj = a_i;
        fr = h - CW'(1) - a_c;
        fc = a_r;
      end
      2'd2: begin
        li = a_n - CW'(1) - a_i;
        lj = a_n - CW'(1) - a_j;
        fr = h - CW'(1) - a_r;
        fc = w - CW'(1) - a_c;
      end
      2'd3: begin
        li = a_j;
        lj = a_n - CW'(1) - a_i;
        fr = a_c;
        fc = w - CW'(1) - a_r;
      end
      default: begin
        li = a_i;
        lj = a_j;
      end
    endcase
    if (a_inreg) begin
      src_r = st + li;
      src_c = sl + lj;
    end else if (a_full) begin
      src_r = fr;
      src_c = fc;
    end else begin
      src_r = a_r;
      src_c = a_c;
    end
    c_inc = a_c + CW'(1);
    r_inc = a_r + CW'(1);
  end

  // load index
  logic [TOT_W-1:0] ld_idx, ld_inc;

  always_comb begin
    ld_idx = (TOT_W'(load_count) >= a_total) ? '0 : TOT_W'(load_count);
    ld_inc = ld_idx + TOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= CFG_DATA_W'(256);
      image_height  <= CFG_DATA_W'(256);
      sel_left      <= '0;
      sel_top       <= '0;
      sel_right     <= CFG_DATA_W'(256);
      sel_bottom    <= CFG_DATA_W'(256);
      quarter_turns <= '0;
      colour_mode   <= 1'b0;
      load_count    <= '0;
      out_row       <= '0;
      out_col       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:   image_width   <= cfg_data;
          REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          REG_SEL_LEFT:      sel_left      <= cfg_data;
          REG_SEL_TOP:       sel_top       <= cfg_data;
          REG_SEL_RIGHT:     sel_right     <= cfg_data;
          REG_SEL_BOTTOM:    sel_bottom    <= cfg_data;
          REG_QUARTER_TURNS: quarter_turns <= cfg_data[1:0];
          REG_COLOUR_MODE:   colour_mode   <= cfg_data[0];
          default:           colour_mode   <= colour_mode;
        endcase
      end
      if (cmd.write) begin
        load_count <= (ld_inc >= a_total) ? '0 : ADDR_W'(ld_inc);
      end
      if (cmd.map) begin
        if (c_inc >= a_ow) begin
          out_col <= '0;
          out_row <= (r_inc >= a_oh) ? '0 : POS_W'(r_inc);
        end else begin
          out_col <= POS_W'(c_inc);
          out_row <= POS_W'(a_r);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_fetch <= func;
      item_pixel <= PIXEL_BITS'(pixel_in);
    end
    if (cmd.prep) begin
      a_r     <= r;
      a_c     <= c;
      a_i     <= r - st;
      a_j     <= c - sl;
      a_n     <= sre - sl;
      a_ow    <= ow;
      a_oh    <= oh;
      a_inreg <= square && (r >= st) && (r < sb) && (c >= sl) && (c < sre);
      a_full  <= full;
      a_total <= TOT_W'(w) * TOT_W'(h);
    end
    if (cmd.map) begin
      b_sr   <= POS_W'(src_r);
      b_sc   <= POS_W'(src_c);
      b_last <= (a_r == a_oh - CW'(1)) && (a_c == a_ow - CW'(1));
    end
    if (cmd.addr) begin
      rd_addr <= ADDR_W'(TOT_W'(b_sr) * TOT_W'(w) + TOT_W'(b_sc));
    end
    if (cmd.out_load) begin
      if (colour_mode) begin
        pixel_out <= PIX_PORT_W'(rdata);
      end else begin
        pixel_out <= PIX_PORT_W'(rdata[GREY_BITS-1:0]);
      end
      last_pixel <= b_last;
    end
  end

  // pixel store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      store[ADDR_W'(ld_idx)] <= item_pixel;
    end
    if (cmd.read) begin
      rdata <= store[rd_addr];
    end
  end

  assign sts.item_fetch = item_fetch;

endmodule

@@ src/image_quarter_turn_rotator.sv @@
// top level of the quarter-turn image rotator
// depends on iqtr_pkg, iqtr_ctrl and iqtr_datapath
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    func, pixel_in
//  out      source     out_valid / out_ready  pixel_out, last_pixel
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item at a time: a load beat goes through capture, set-up and store write,
// a fetch beat through capture, set-up, mapping, address multiply, store read and output fill;
// the single-port pixel store and the address multiply set these steps
// rst is synchronous: config registers return to a 256 x 256 whole-image view, no turn,
// grey; load count and output position go to zero; the pixel store is not cleared
// the output register holds a result while out_ready is low and the next beat is taken
// meanwhile; only the final fill waits for the output register to free up
// cfg_ready is always high; writes must be made while no beat is in flight, not enforced here
module image_quarter_turn_rotator import iqtr_pkg::*; #(
  parameter int MAX_DIM    = 256,
  parameter int PIXEL_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [PIX_PORT_W-1:0]  pixel_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIX_PORT_W-1:0]  pixel_out,
  output logic                   last_pixel,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  iqtr_cmd_t cmd;
  iqtr_sts_t sts;

  // config writes are never stalled
  assign cfg_ready = 1'b1;

  // sequencing
  iqtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, address mapping and store
  iqtr_datapath #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (func),
    .pixel_in   (pixel_in),
    .pixel_out  (pixel_out),
    .last_pixel (last_pixel),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ tb/image_quarter_turn_rotator_tb.sv @@
// self-checking testbench for the quarter-turn image rotator
// depends on iqtr_pkg and image_quarter_turn_rotator; holds its own rotation predictor
// and drives loads, fetches and register writes with random gaps on both channels
module image_quarter_turn_rotator_tb;
  import iqtr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM     = 256;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int SETTLE_CYCLES = 12;   // room for a trailing fetch or load to finish

  typedef struct packed {
    logic [PIX_PORT_W-1:0] px;
    logic                  last;
  } out_pixel_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   func = FUNC_LOAD;
  logic [PIX_PORT_W-1:0]  pixel_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PIX_PORT_W-1:0]  pixel_out;
  logic                   last_pixel;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  image_quarter_turn_rotator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .last_pixel (last_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a shadow of the register file, the pixel store, the load
  // pointer and the output raster position, all at their reset values
  // ---------------------------------------------------------------------------
  logic [PIX_PORT_W-1:0] pixel_mem [0:STORE_DEPTH-1];
  logic [CFG_DATA_W-1:0] width_reg = 9'd256;
  logic [CFG_DATA_W-1:0] height_reg = 9'd256;
  logic [CFG_DATA_W-1:0] left_reg = 9'd0;
  logic [CFG_DATA_W-1:0] top_reg = 9'd0;
  logic [CFG_DATA_W-1:0] right_reg = 9'd256;
  logic [CFG_DATA_W-1:0] bottom_reg = 9'd256;
  logic [1:0]            turns_reg = 2'd0;
  logic                  colour_reg = 1'b0;
  int                    load_ptr = 0;
  int                    fetch_row = 0;
  int                    fetch_col = 0;

  // pixels from index 0 up to this length are known to hold written data;
  // fetches are only issued once the current image lies inside it
  int filled_len = 0;

  out_pixel_t pending_pixels[$];   // rotated pixels still owed by the block
  int         fail_count = 0;
  int         random_items = 0;
  int         rx_hold = 0;
  bit         tx_calm = 1'b0;      // no gaps on the input and config side
  bit         rx_calm = 1'b0;      // no stalls on the output side

  // zero reads as one, anything past the maximum as the maximum
  function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // no gap or a short one most of the time, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PIX_PORT_W-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_PORT_W'($urandom);
  endfunction

  // load beat: write at the load pointer, which wraps at the image end and
  // restarts at pixel 0 if the image shrank underneath it
  function automatic void store_load(input logic [PIX_PORT_W-1:0] px);
    int total;
    int idx;
    total = clamp_dim(width_reg) * clamp_dim(height_reg);
    idx = load_ptr;
    if (idx >= total) idx = 0;
    pixel_mem[idx] = px;
    idx++;
    load_ptr = (idx >= total) ? 0 : idx;
  endfunction

  // fetch beat: map the current output position back to a stored pixel
  function automatic out_pixel_t rotate_fetch();
    int w, h, t, ow, oh, r, c, sr, sc, n, i, j, li, lj;
    int x0, y0, x1, y1;
    bit whole, square, full_turn;
    out_pixel_t res;
    w  = clamp_dim(width_reg);
    h  = clamp_dim(height_reg);
    t  = turns_reg;
    x0 = left_reg;
    y0 = top_reg;
    x1 = right_reg;
    y1 = bottom_reg;
    whole  = (x0 == 0) && (y0 == 0) && (x1 == w) && (y1 == h);
    square = (x1 > x0) && (y1 > y0) && ((x1 - x0) == (y1 - y0)) && (x1 <= w) && (y1 <= h);
    full_turn = !square && whole;
    ow = w;
    oh = h;
    // odd turns of a non-square whole image swap the output dimensions
    if (full_turn && (t % 2 == 1)) begin
      ow = h;
      oh = w;
    end
    // position left off the image by a dimension change restarts the raster
    if (fetch_row >= oh || fetch_col >= ow) begin
      fetch_row = 0;
      fetch_col = 0;
    end
    r  = fetch_row;
    c  = fetch_col;
    sr = r;
    sc = c;
    if (square) begin
      n = x1 - x0;
      if (r >= y0 && r < y1 && c >= x0 && c < x1) begin
        i  = r - y0;
        j  = c - x0;
        li = i;
        lj = j;
        case (t)
          1: begin
            li = n - 1 - j;
            lj = i;
          end
          2: begin
            li = n - 1 - i;
            lj = n - 1 - j;
          end
          3: begin
            li = j;
            lj = n - 1 - i;
          end
          default: ;
        endcase
        sr = y0 + li;
        sc = x0 + lj;
      end
    end else if (full_turn) begin
      case (t)
        1: begin
          sr = h - 1 - c;
          sc = r;
        end
        2: begin
          sr = h - 1 - r;
          sc = w - 1 - c;
        end
        3: begin
          sr = c;
          sc = w - 1 - r;
        end
        default: ;
      endcase
    end
    res.px = pixel_mem[sr * w + sc];
    if (!colour_reg) res.px[PIX_PORT_W-1:GREY_BITS] = '0;
    res.last = (r == oh - 1) && (c == ow - 1);
    if (c + 1 >= ow) begin
      fetch_col = 0;
      fetch_row = (r + 1 >= oh) ? 0 : r + 1;
    end else begin
      fetch_col = c + 1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random back-pressure, and every accepted beat is held
  // against the oldest owed pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : out_side
    out_pixel_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 100)
            $display("%0t: unexpected beat, expected none, actual pixel %h last %b",
                     $time, pixel_out, last_pixel);
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_out !== want.px) begin
            fail_count++;
            if (fail_count <= 100)
              $display("%0t: pixel_out expected %h, actual %h", $time, want.px, pixel_out);
          end
          if (last_pixel !== want.last) begin
            fail_count++;
            if (fail_count <= 100)
              $display("%0t: last_pixel expected %b, actual %b", $time, want.last, last_pixel);
          end
        end
      end
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
        rx_hold = pick_gap(rx_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one beat on the item channel; valid is only dropped when a gap follows,
  // so back-to-back beats never see valid lowered and raised in one step
  task automatic send_item(input logic f, input logic [PIX_PORT_W-1:0] px);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (f == FUNC_LOAD) store_load(px);
    else pending_pixels.push_back(rotate_fetch());
  endtask

  // one beat on the config channel, mirrored into the shadow registers
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg  = val;
      REG_IMAGE_HEIGHT:  height_reg = val;
      REG_SEL_LEFT:      left_reg   = val;
      REG_SEL_TOP:       top_reg    = val;
      REG_SEL_RIGHT:     right_reg  = val;
      REG_SEL_BOTTOM:    bottom_reg = val;
      REG_QUARTER_TURNS: turns_reg  = val[1:0];
      REG_COLOUR_MODE:   colour_reg = val[0];
      default: ;
    endcase
  endtask

  // let the block go idle: all owed pixels in, then time for a trailing load
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full register set, written only once the block is idle; the unused upper
  // bits of the turn and colour writes carry random junk
  task automatic configure(input int wv, input int hv, input int x0, input int y0,
                           input int x1, input int y1, input int t, input bit colour);
    drain();
    write_reg(REG_IMAGE_WIDTH,   CFG_DATA_W'(wv));
    write_reg(REG_IMAGE_HEIGHT,  CFG_DATA_W'(hv));
    write_reg(REG_SEL_LEFT,      CFG_DATA_W'(x0));
    write_reg(REG_SEL_TOP,       CFG_DATA_W'(y0));
    write_reg(REG_SEL_RIGHT,     CFG_DATA_W'(x1));
    write_reg(REG_SEL_BOTTOM,    CFG_DATA_W'(y1));
    write_reg(REG_QUARTER_TURNS, {7'($urandom), 2'(t)});
    write_reg(REG_COLOUR_MODE,   {8'($urandom), colour});
    cfg_valid <= 1'b0;
  endtask

  // a full image's worth of loads covers every pixel wherever the pointer starts
  task automatic load_image(input int count);
    repeat (count) send_item(FUNC_LOAD, rand_pixel());
    if (count > filled_len) filled_len = count;
  endtask

  task automatic fetch_pixels(input int count);
    repeat (count) send_item(FUNC_FETCH, rand_pixel());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // loads under the reset view push the load pointer past a small image
  task automatic test_reset_view_loads();
    repeat (7) send_item(FUNC_LOAD, rand_pixel());
  endtask

  // 3 x 2 whole image: quarter turn in colour with extreme pixels, the first
  // load wrapping to pixel 0, then a half turn in grey
  task automatic test_whole_image_turns();
    logic [PIX_PORT_W-1:0] corner_px [6];
    corner_px = '{24'h000000, 24'hFFFFFF, 24'h800001, 24'h7FFFFE, 24'hAAAAAA, 24'h555555};
    configure(3, 2, 0, 0, 3, 2, 1, 1'b1);
    foreach (corner_px[k]) send_item(FUNC_LOAD, corner_px[k]);
    if (filled_len < 6) filled_len = 6;
    fetch_pixels(6);
    configure(3, 2, 0, 0, 3, 2, 2, 1'b0);
    fetch_pixels(6);
  endtask

  // largest dimensions, reached through clamped register values: a tall
  // column turned a quarter, a wide row turned three quarters over the same
  // 256 loaded pixels, and a one-pixel square at the far edge; the raster
  // position falls off the image at each change of view and restarts at the origin
  task automatic test_dimension_extremes();
    configure(0, 511, 0, 0, 1, 256, 1, 1'($urandom));
    load_image(256);
    fetch_pixels(48);
    configure(511, 0, 0, 0, 256, 1, 3, 1'b1);
    fetch_pixels(48);
    configure(256, 1, 255, 0, 256, 1, 2, 1'($urandom));
    fetch_pixels(40);
  endtask

  // random images, selections, turns and modes, with a raster of fetches and
  // a few loads mixed in after each configuration
  task automatic test_random_phases();
    int wv, hv, w, h, m, n, x0, y0, x1, y1, total, steps;
    while (random_items < 180) begin
      if ($urandom_range(0, 9) == 0) begin
        // one dimension at an extreme, the other kept to a single pixel
        case ($urandom_range(0, 3))
          0: wv = 0;
          1: wv = 256;
          2: wv = $urandom_range(257, 511);
          default: wv = 255;
        endcase
        hv = 1;
        if ($urandom_range(0, 1) == 1) begin
          n  = wv;
          wv = hv;
          hv = n;
        end
      end else begin
        wv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        hv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      end
      w = clamp_dim(CFG_DATA_W'(wv));
      h = clamp_dim(CFG_DATA_W'(hv));
      m = (w < h) ? w : h;
      total = w * h;

      case ($urandom_range(0, 9))
        0, 1: begin
          // whole image, square or not
          x0 = 0; y0 = 0; x1 = w; y1 = h;
        end
        2, 3, 4: begin
          n  = $urandom_range(1, m);
          x0 = $urandom_range(0, w - n);
          y0 = $urandom_range(0, h - n);
          x1 = x0 + n; y1 = y0 + n;
        end
        5: begin
          // largest square pushed into the far corner
          x0 = w - m; y0 = h - m; x1 = w; y1 = h;
        end
        6: begin
          // empty selection
          x0 = $urandom_range(0, w); x1 = x0;
          y0 = $urandom_range(0, h); y1 = y0;
        end
        7: begin
          // reversed selection
          x0 = $urandom_range(1, w); x1 = $urandom_range(0, x0 - 1);
          y0 = $urandom_range(0, h); y1 = $urandom_range(0, h);
        end
        8: begin
          if ($urandom_range(0, 1) == 0) begin
            // square running off the right edge
            x0 = $urandom_range(0, w - 1);
            n  = w - x0 + $urandom_range(1, 3);
            y0 = 0; x1 = x0 + n; y1 = n;
          end else begin
            x0 = 0; y0 = 0;
            x1 = $urandom_range(1, w); y1 = $urandom_range(1, h);
          end
        end
        default: begin
          x0 = $urandom_range(0, 511); y0 = $urandom_range(0, 511);
          x1 = $urandom_range(0, 511); y1 = $urandom_range(0, 511);
        end
      endcase

      configure(wv, hv, x0, y0, x1, y1, $urandom_range(0, 3), 1'($urandom));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);

      // long images reuse what is already stored if it covers them; short ones are mostly reloaded
      if (filled_len < total || (total <= 64 && $urandom_range(0, 3) != 0)) begin
        load_image(total);
        random_items += total;
      end
      steps = $urandom_range(total / 2 + 1, 2 * total + 2);
      if (steps > 60) steps = 60;
      repeat (steps) begin
        if ($urandom_range(0, 4) == 0) send_item(FUNC_LOAD, rand_pixel());
        else send_item(FUNC_FETCH, rand_pixel());
        random_items++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_view_loads();
    test_whole_image_turns();
    test_dimension_extremes();
    test_random_phases();

    // every owed pixel in, then a quiet stretch to catch strays
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/iqtr_pkg.sv
src/iqtr_ctrl.sv
src/iqtr_datapath.sv
src/image_quarter_turn_rotator.sv
tb/image_quarter_turn_rotator_tb.sv
